@@ hw/rtl/bcg_pkg.sv @@
package bcg_pkg;

	localparam int SAMPLE_BITS = 24;
	localparam int BAND_MAX = 4;
	localparam int GAIN_W = 15;
	localparam int DB_W = 16;

	localparam logic [GAIN_W-1:0] UNITY_GAIN = 15'd16384;
	localparam logic [15:0] LINK_ON_ABOVE = 16'd655;
	localparam logic [18:0] DB_PER_OCTAVE = 19'd394566;
	localparam logic [13:0] OCTAVE_PER_DB = 14'd10885;

	localparam int LEVEL_FLOOR_RAW = ((1 << (SAMPLE_BITS - 1)) + 50000) / 100000;
	localparam logic [SAMPLE_BITS-1:0] LEVEL_FLOOR =
		SAMPLE_BITS'((LEVEL_FLOOR_RAW == 0) ? 1 : LEVEL_FLOOR_RAW);

	typedef enum logic [2:0] {
		REG_BAND0,
		REG_BAND1,
		REG_BAND2,
		REG_BAND3,
		REG_MAKEUP,
		REG_MASK,
		REG_LINK,
		REG_STEREO
	} cfg_reg_e;

	typedef struct packed {
		logic                          channel;
		logic [1:0]                    band;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic signed [SAMPLE_BITS-1:0] other_sample;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] band_out;
		logic [GAIN_W-1:0]             envelope_gain;
		logic signed [DB_W-1:0]        reduction_db;
	} out_item_t;

	// item handed from the front to the back
	typedef struct packed {
		logic                          bypass;
		logic                          channel;
		logic [1:0]                    band;
		logic signed [SAMPLE_BITS-1:0] sample;
		logic [SAMPLE_BITS-1:0]        level;
	} work_t;

	typedef struct packed {
		logic [BAND_MAX-1:0][63:0] band_set;
		logic [BAND_MAX-1:0][15:0] makeup;
		logic [BAND_MAX-1:0]       mask;
		logic [15:0]               link;
		logic                      stereo;
	} cfg_t;

	typedef logic [29:0] root_t;
	typedef root_t root_tab_t [16];

	function automatic logic [63:0] isqrt64(input logic [63:0] val);
		logic [63:0] v;
		logic [63:0] res;
		logic [63:0] bt;
		v = val;
		res = '0;
		bt = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (bt > v) bt = bt >> 2;
		end
		for (int i = 0; i < 32; i++) begin
			if (bt != 64'd0) begin
				if (v >= res + bt) begin
					v = v - (res + bt);
					res = (res >> 1) + bt;
				end else begin
					res = res >> 1;
				end
				bt = bt >> 2;
			end
		end
		return res;
	endfunction

	// 2^(-2^-(k+1)) in Q30 by successive square roots
	function automatic root_tab_t build_roots();
		root_tab_t t;
		logic [63:0] prev;
		prev = 64'd1 << 29;
		for (int k = 0; k < 16; k++) begin
			prev = isqrt64(prev << 30);
			t[k] = prev[29:0];
		end
		return t;
	endfunction

	localparam root_tab_t ROOTS = build_roots();

endpackage

@@ hw/rtl/bcg_fifo.sv @@
module bcg_fifo #(
	parameter int Width = 1,
	parameter int Depth = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [Width-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [Width-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CNT_W = $clog2(Depth + 1);

	logic [Width-1:0] mem_q [Depth];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full = (count_q == CNT_W'(Depth));
	assign empty = (count_q == '0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_W'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= (rd_ptr_q == PTR_W'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !push) count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_data;
	end

endmodule

@@ hw/rtl/bcg_front.sv @@
module bcg_front #(
	parameter int BAND_COUNT = 4,
	parameter int CHANNEL_COUNT = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bcg_pkg::in_item_t  in_data,
	input  bcg_pkg::cfg_t      cfg,
	output logic               push,
	output bcg_pkg::work_t     push_data,
	input  logic               full
);

	localparam int SB = bcg_pkg::SAMPLE_BITS;
	localparam int P_W = SB + 17;

	logic v_s1, v_s2;
	logic go1, ld1, ld2;

	logic                 bypass_s1, ch_s1, link_s1;
	logic [1:0]           band_s1;
	logic signed [SB-1:0] sample_s1;
	logic [SB-1:0]        own_s1, mx_s1;

	logic                 bypass_s2, ch_s2, link_s2;
	logic [1:0]           band_s2;
	logic signed [SB-1:0] sample_s2;
	logic [SB-1:0]        mx_s2;
	logic [P_W-1:0]       p_s2;

	logic          multi;
	logic [SB-1:0] own_c, other_c, mx_c;
	logic [16:0]   inv_link;
	logic [P_W-1:0] sum_c;
	logic [SB-1:0] lvl_c;

	assign push = v_s2 && !full;
	assign ld2 = !v_s2 || push;
	assign go1 = v_s1 && ld2;
	assign ld1 = !v_s1 || go1;
	assign in_ready = ld1;

	assign multi = cfg.stereo && (CHANNEL_COUNT > 1);
	assign inv_link = 17'h10000 - {1'b0, cfg.link};

	always_comb begin
		own_c = in_data.sample[SB-1] ? SB'(-in_data.sample) : SB'(in_data.sample);
		other_c = own_c;
		if (multi) begin
			other_c = in_data.other_sample[SB-1] ? SB'(-in_data.other_sample)
				: SB'(in_data.other_sample);
		end
		mx_c = (other_c > own_c) ? other_c : own_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_valid;
			if (ld2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1 && in_valid) begin
			bypass_s1 <= (32'(in_data.band) >= BAND_COUNT) ||
				(32'(in_data.channel) >= CHANNEL_COUNT);
			ch_s1 <= in_data.channel;
			band_s1 <= in_data.band;
			sample_s1 <= in_data.sample;
			own_s1 <= own_c;
			mx_s1 <= mx_c;
			link_s1 <= multi && (cfg.link > bcg_pkg::LINK_ON_ABOVE);
		end
		if (go1) begin
			bypass_s2 <= bypass_s1;
			ch_s2 <= ch_s1;
			band_s2 <= band_s1;
			sample_s2 <= sample_s1;
			mx_s2 <= mx_s1;
			link_s2 <= link_s1;
			p_s2 <= link_s1 ? P_W'(own_s1) * P_W'(inv_link) : P_W'({own_s1, 16'h0000});
		end
	end

	// linked level is own*(1-L) + max*L
	always_comb begin
		sum_c = p_s2;
		if (link_s2) sum_c = p_s2 + P_W'(mx_s2) * P_W'(cfg.link);
		lvl_c = sum_c[SB+15:16];
		if (lvl_c < bcg_pkg::LEVEL_FLOOR) lvl_c = bcg_pkg::LEVEL_FLOOR;
	end

	always_comb begin
		push_data.bypass = bypass_s2;
		push_data.channel = ch_s2;
		push_data.band = band_s2;
		push_data.sample = sample_s2;
		push_data.level = lvl_c;
	end

endmodule

@@ hw/rtl/bcg_back.sv @@
module bcg_back #(
	parameter int BAND_COUNT = 4,
	parameter int CHANNEL_COUNT = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  bcg_pkg::cfg_t      cfg,
	output logic               pop,
	input  bcg_pkg::work_t     pop_data,
	input  logic               empty,
	output logic               out_valid,
	input  logic               out_ready,
	output bcg_pkg::out_item_t out_data
);

	localparam int SB = bcg_pkg::SAMPLE_BITS;
	localparam int ENV_DEPTH = BAND_COUNT * CHANNEL_COUNT;
	localparam int IDX_W = (ENV_DEPTH > 1) ? $clog2(ENV_DEPTH) : 1;
	localparam int P1_W = SB + 15;
	localparam int P2_W = SB + 31;
	localparam int PR_W = P2_W - 28;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOG_INIT,
		ST_LOG_ITER,
		ST_DB,
		ST_OVER,
		ST_RED,
		ST_EXP_INIT,
		ST_EXP_ITER,
		ST_TARGET,
		ST_ENV1,
		ST_ENV2,
		ST_MUL1,
		ST_MUL2,
		ST_DONE
	} state_t;

	state_t state_q;
	logic out_valid_q;
	bcg_pkg::out_item_t out_q;
	logic [14:0] env_mem_q [ENV_DEPTH];

	bcg_pkg::work_t it_q;
	logic           pass_q;
	logic [4:0]     lg_e_q;
	logic [30:0]    lg_m_q;
	logic [15:0]    frac_q;
	logic [3:0]     cnt_q;
	logic [15:0]    dbv_q, over_q, red_q, f_q;
	logic [4:0]     n_q;
	logic [30:0]    v_q;
	logic [14:0]    target_q, env_q;
	logic [30:0]    acc_q;
	logic [16:0]    cbar_q;
	logic [P1_W-1:0] p_q;
	logic signed [SB-1:0] bo_q;
	logic [15:0]    rdb_q;

	logic [63:0]    set;
	logic signed [15:0] thr;
	logic [15:0]    slope, atk, rel, mk, c;
	logic [IDX_W-1:0] idx;
	logic [SB-1:0]  lg_x;
	logic [4:0]     lg_e_c;
	logic [30:0]    lg_xw;
	logic [61:0]    sq;
	logic [31:0]    sq_t;
	logic [20:0]    l_c, ref_c, d_c;
	logic [39:0]    dprod;
	logic [15:0]    dbv_c, rclamp;
	logic signed [17:0] db_c, thr_c, diff_c;
	logic [31:0]    red_p;
	logic [29:0]    rp;
	logic [60:0]    vp;
	logic [5:0]     sh;
	logic [63:0]    tsum;
	logic [14:0]    env_old, env_new;
	logic [32:0]    esum;
	logic [SB-1:0]  mag;
	logic [P2_W-1:0] pr;
	logic [PR_W-1:0] prod;
	logic signed [SB-1:0] bo_c;
	logic           out_load;

	assign set = cfg.band_set[it_q.band];
	assign thr = signed'(set[15:0]);
	assign slope = set[31:16];
	assign atk = set[47:32];
	assign rel = set[63:48];
	assign mk = cfg.makeup[it_q.band];
	assign idx = IDX_W'(int'(it_q.band) * CHANNEL_COUNT + int'(it_q.channel));
	assign env_old = env_mem_q[idx];
	assign c = (target_q < env_old) ? atk : rel;

	assign pop = (state_q == ST_IDLE) && !empty;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;
	assign out_data = out_q;

	// log2 front end: leading one and normalize to Q30
	always_comb begin
		lg_x = pass_q ? SB'(env_q) : it_q.level;
		if (lg_x == '0) lg_x = SB'(1);
		lg_e_c = '0;
		for (int i = 0; i < SB; i++) begin
			if (lg_x[i]) lg_e_c = 5'(i);
		end
		lg_xw = 31'(lg_x);
	end

	assign sq = lg_m_q * lg_m_q;
	assign sq_t = sq[61:30];

	always_comb begin
		l_c = {lg_e_q, frac_q};
		ref_c = pass_q ? 21'(14 << 16) : 21'((SB - 1) << 16);
		d_c = (l_c >= ref_c) ? '0 : ref_c - l_c;
		dprod = 40'(d_c) * 40'(bcg_pkg::DB_PER_OCTAVE) + 40'(1 << 23);
		dbv_c = dprod[39:24];
		rclamp = (dbv_c > 16'd32768) ? 16'd32768 : dbv_c;
		db_c = -signed'({2'b00, dbv_q});
		thr_c = 18'(thr);
		diff_c = db_c - thr_c;
	end

	assign red_p = over_q * slope;
	assign rp = 30'(red_q) * 30'(bcg_pkg::OCTAVE_PER_DB);
	assign vp = v_q * bcg_pkg::ROOTS[cnt_q];
	assign sh = 6'(n_q) + 6'd16;
	assign tsum = 64'(v_q) + (64'd1 << (sh - 6'd1));

	always_comb begin
		esum = 33'(acc_q) + 33'(cbar_q) * 33'(target_q) + 33'd32768;
		env_new = esum[30:16];
		if (!cfg.mask[it_q.band]) env_new = bcg_pkg::UNITY_GAIN;
	end

	assign mag = it_q.sample[SB-1] ? SB'(-it_q.sample) : SB'(it_q.sample);
	assign pr = P2_W'(p_q) * P2_W'(mk) + P2_W'(1 << 27);
	assign prod = pr[P2_W-1:28];

	// round half away from zero, then saturate
	always_comb begin
		if (it_q.sample[SB-1]) begin
			bo_c = (prod >= PR_W'(1 << (SB - 1))) ? {1'b1, {(SB - 1){1'b0}}}
				: SB'(~prod + 1'b1);
		end else begin
			bo_c = (prod > PR_W'((1 << (SB - 1)) - 1)) ? {1'b0, {(SB - 1){1'b1}}}
				: SB'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			out_q <= '0;
			for (int i = 0; i < ENV_DEPTH; i++) env_mem_q[i] <= bcg_pkg::UNITY_GAIN;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_q.band_out <= bo_q;
				out_q.envelope_gain <= env_q;
				out_q.reduction_db <= signed'(rdb_q);
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == ST_ENV2) env_mem_q[idx] <= env_new;
			unique case (state_q)
				ST_IDLE: if (pop) state_q <= pop_data.bypass ? ST_DONE : ST_LOG_INIT;
				ST_LOG_INIT: state_q <= ST_LOG_ITER;
				ST_LOG_ITER: if (cnt_q == 4'd15) state_q <= ST_DB;
				ST_DB: state_q <= pass_q ? ST_DONE : ST_OVER;
				ST_OVER: state_q <= ST_RED;
				ST_RED: state_q <= ST_EXP_INIT;
				ST_EXP_INIT: state_q <= ST_EXP_ITER;
				ST_EXP_ITER: if (cnt_q == 4'd15) state_q <= ST_TARGET;
				ST_TARGET: state_q <= ST_ENV1;
				ST_ENV1: state_q <= ST_ENV2;
				ST_ENV2: state_q <= ST_MUL1;
				ST_MUL1: state_q <= ST_MUL2;
				ST_MUL2: state_q <= (env_q == '0) ? ST_DONE : ST_LOG_INIT;
				ST_DONE: if (out_load) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					it_q <= pop_data;
					pass_q <= 1'b0;
					bo_q <= pop_data.sample;
					env_q <= bcg_pkg::UNITY_GAIN;
					rdb_q <= '0;
				end
			end
			ST_LOG_INIT: begin
				lg_e_q <= lg_e_c;
				lg_m_q <= lg_xw << (5'd30 - lg_e_c);
				frac_q <= '0;
				cnt_q <= '0;
			end
			ST_LOG_ITER: begin
				lg_m_q <= sq_t[31] ? sq_t[31:1] : sq_t[30:0];
				frac_q <= {frac_q[14:0], sq_t[31]};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_DB: begin
				dbv_q <= dbv_c;
				if (pass_q) rdb_q <= ~rclamp + 1'b1;
			end
			ST_OVER: over_q <= (db_c > thr_c) ? diff_c[15:0] : '0;
			ST_RED: red_q <= red_p[31:16];
			ST_EXP_INIT: begin
				n_q <= rp[28:24];
				f_q <= rp[23:8];
				v_q <= 31'd1 << 30;
				cnt_q <= '0;
			end
			ST_EXP_ITER: begin
				if (f_q[15]) v_q <= vp[60:30];
				f_q <= {f_q[14:0], 1'b0};
				cnt_q <= cnt_q + 1'b1;
			end
			ST_TARGET: target_q <= 15'(tsum >> sh);
			ST_ENV1: begin
				acc_q <= 31'(c) * 31'(env_old);
				cbar_q <= 17'h10000 - {1'b0, c};
			end
			ST_ENV2: env_q <= env_new;
			ST_MUL1: p_q <= P1_W'(mag) * P1_W'(env_q);
			ST_MUL2: begin
				bo_q <= bo_c;
				pass_q <= 1'b1;
				if (env_q == '0) rdb_q <= 16'h8000;
			end
			default: ;
		endcase
	end

endmodule

@@ hw/rtl/band_compressor_gain_stage.sv @@
// datapath: front stages s1 and s2, the FIFO, then the back sequencer, which takes one
//   item at a time while idle; a band or channel out of range skips the loops below
// the sequencer runs a 16-step squaring loop (log2), a 16-step root product loop (exp)
//   and then a second 16-step log2 loop on the new envelope unless that gain is zero
// reset: asynchronous, active low; all envelopes return to unity, registers to defaults
module band_compressor_gain_stage #(
	parameter int BAND_COUNT = 4,
	parameter int CHANNEL_COUNT = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  bcg_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output bcg_pkg::out_item_t out_data,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data
);

	bcg_pkg::cfg_t cfg_q;
	bcg_pkg::work_t push_data, pop_data;
	logic push, pop, full, empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_set <= '0;
			cfg_q.makeup <= 64'h4000400040004000;
			cfg_q.mask <= 4'hf;
			cfg_q.link <= '0;
			cfg_q.stereo <= 1'b1;
		end else if (cfg_valid) begin
			unique case (bcg_pkg::cfg_reg_e'(cfg_index)) inside
				bcg_pkg::REG_BAND0, bcg_pkg::REG_BAND1, bcg_pkg::REG_BAND2,
				bcg_pkg::REG_BAND3: cfg_q.band_set[cfg_index[1:0]] <= cfg_data;
				bcg_pkg::REG_MAKEUP: cfg_q.makeup <= cfg_data;
				bcg_pkg::REG_MASK: cfg_q.mask <= cfg_data[3:0];
				bcg_pkg::REG_LINK: cfg_q.link <= cfg_data[15:0];
				bcg_pkg::REG_STEREO: cfg_q.stereo <= cfg_data[0];
				default: ;
			endcase
		end
	end

	bcg_front #(
		.BAND_COUNT(BAND_COUNT),
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.cfg(cfg_q),
		.push(push),
		.push_data(push_data),
		.full(full)
	);

	bcg_fifo #(
		.Width($bits(bcg_pkg::work_t)),
		.Depth(2)
	) u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.full(full),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty)
	);

	bcg_back #(
		.BAND_COUNT(BAND_COUNT),
		.CHANNEL_COUNT(CHANNEL_COUNT)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.pop(pop),
		.pop_data(pop_data),
		.empty(empty),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.envelope_gain <= bcg_pkg::UNITY_GAIN)
		else $error("envelope above unity");

	a_db_sign: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.reduction_db[15] || out_data.reduction_db == '0))
		else $error("positive reduction");

	a_unity_db: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.envelope_gain == bcg_pkg::UNITY_GAIN)
		|-> out_data.reduction_db == '0)
		else $error("unity gain with nonzero reduction");

endmodule
